/* src/rcr_pkg.sv */
// Shared types, codes and constants of the read-coils responder.
`timescale 1ns / 1ps

package rcr_pkg;

    // Coil store geometry: 65536 coils kept as 8192 rows of 8 coils.
    localparam int COIL_ROWS = 8192;
    localparam int ROW_W     = 13;

    localparam logic [15:0] MAX_QUANTITY = 16'd2000;

    localparam logic [7:0] EXC_FLAG          = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'h02;
    localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'h03;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_TRUNC     = 2'd1;
    localparam logic [1:0] STS_BUF_SMALL = 2'd2;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_COIL = 1'b1;

    localparam logic [1:0] CFG_ADDR_LOW  = 2'd0;
    localparam logic [1:0] CFG_ADDR_HIGH = 2'd1;
    localparam logic [1:0] CFG_BUF_SIZE  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_READ,
        ST_WR_WRITE,
        ST_CHECK,
        ST_FETCH,
        ST_SHIFT,
        ST_PUSH
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic clr_write;
        logic coil_read;
        logic coil_write;
        logic single_load;
        logic resp_start;
        logic row_fetch;
        logic row_shift;
        logic word_push;
    } rcr_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic out_free;
        logic single;
        logic primed;
        logic word_full;
        logic last_word;
    } rcr_sts_t;

    // Keep the low n coils of the final data byte; n of zero keeps all eight.
    function automatic logic [7:0] tail_mask(input logic [2:0] n);
        logic [7:0] m;
        begin
            if (n == 3'd0)
                m = 8'hFF;
            else
                m = (8'h01 << n) - 8'h01;
            return m;
        end
    endfunction

endpackage

/* src/read_coils_responder_core.sv */
// Top level of the read-coils responder: controller plus datapath.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in      | input     | in_valid / in_stall | req_type func_code data_byte last_byte
//          |           |                     | coil_addr coil_value
//  out     | output    | out_valid/out_stall | resp_func_code resp_data resp_nbytes
//          |           |                     | resp_last status
//  cfg     | input     | cfg_we              | cfg_index cfg_data
//
// A request data byte is taken in ST_IDLE; a coil write is a read-modify-write of an 8-coil row.
// The last request byte leads to a check in ST_CHECK; a normal response then streams the coil store
// one row per ST_FETCH/ST_SHIFT pair, plus an ST_PUSH step per 8-byte result word.
// After reset the coil store is cleared, all 8192 rows, one row a cycle; in_stall stays high.
// out_stall holds the finished word in the output register and pauses the row stream.
`timescale 1ns / 1ps

module read_coils_responder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  func_code,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [15:0] coil_addr,
    input  logic        coil_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  resp_func_code,
    output logic [63:0] resp_data,
    output logic [3:0]  resp_nbytes,
    output logic        resp_last,
    output logic [1:0]  status
);

    rcr_pkg::rcr_cmd_t cmd;
    rcr_pkg::rcr_sts_t sts;

    rcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .last_byte (last_byte),
        .sts       (sts),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    rcr_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_type       (req_type),
        .func_code      (func_code),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .coil_addr      (coil_addr),
        .coil_value     (coil_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .resp_func_code (resp_func_code),
        .resp_data      (resp_data),
        .resp_nbytes    (resp_nbytes),
        .resp_last      (resp_last),
        .status         (status)
    );

endmodule

/* src/rcr_ctrl.sv */
// Controller state machine of the read-coils responder.
`timescale 1ns / 1ps

module rcr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              req_type,
    input  logic              last_byte,
    input  rcr_pkg::rcr_sts_t sts,
    output logic              in_stall,
    output rcr_pkg::rcr_cmd_t cmd
);

    rcr_pkg::ctrl_state_t state_reg;
    rcr_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcr_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            rcr_pkg::ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_done)
                    state_next = rcr_pkg::ST_IDLE;
            end
            rcr_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (req_type == rcr_pkg::REQ_COIL)
                        state_next = rcr_pkg::ST_WR_READ;
                    else if (last_byte)
                        state_next = rcr_pkg::ST_CHECK;
                end
            end
            rcr_pkg::ST_WR_READ:
            begin
                cmd.coil_read = 1'b1;
                state_next    = rcr_pkg::ST_WR_WRITE;
            end
            rcr_pkg::ST_WR_WRITE:
            begin
                cmd.coil_write = 1'b1;
                state_next     = rcr_pkg::ST_IDLE;
            end
            rcr_pkg::ST_CHECK:
            begin
                if (!sts.single)
                begin
                    cmd.resp_start = 1'b1;
                    state_next     = rcr_pkg::ST_FETCH;
                end
                else if (sts.out_free)
                begin
                    cmd.single_load = 1'b1;
                    state_next      = rcr_pkg::ST_IDLE;
                end
            end
            rcr_pkg::ST_FETCH:
            begin
                cmd.row_fetch = 1'b1;
                state_next    = rcr_pkg::ST_SHIFT;
            end
            rcr_pkg::ST_SHIFT:
            begin
                cmd.row_shift = 1'b1;
                if (sts.primed && sts.word_full)
                    state_next = rcr_pkg::ST_PUSH;
                else
                    state_next = rcr_pkg::ST_FETCH;
            end
            rcr_pkg::ST_PUSH:
            begin
                // hold the word until the output register frees up
                if (sts.out_free)
                begin
                    cmd.word_push = 1'b1;
                    if (sts.last_word)
                        state_next = rcr_pkg::ST_IDLE;
                    else
                        state_next = rcr_pkg::ST_FETCH;
                end
            end
            default:
            begin
                state_next = rcr_pkg::ST_IDLE;
            end
        endcase
    end

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_write, cmd.coil_read, cmd.coil_write, cmd.single_load,
                  cmd.resp_start, cmd.row_fetch, cmd.row_shift, cmd.word_push}))
        else $error("controller issued two datapath commands at once");

    a_rmw_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.coil_read |=> cmd.coil_write)
        else $error("coil row read not followed by its write-back");

    a_fetch_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_fetch |=> cmd.row_shift)
        else $error("fetched row not shifted into the window");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> (!in_stall && !cmd.clr_write))
        else $error("input beat taken while the block is busy");

endmodule

/* src/rcr_datapath.sv */
// Datapath of the read-coils responder: coil store, request capture, checks, word packing.
`timescale 1ns / 1ps

module rcr_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  rcr_pkg::rcr_cmd_t cmd,
    output rcr_pkg::rcr_sts_t sts,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              req_type,
    input  logic [7:0]        func_code,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic [15:0]       coil_addr,
    input  logic              coil_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        resp_func_code,
    output logic [63:0]       resp_data,
    output logic [3:0]        resp_nbytes,
    output logic              resp_last,
    output logic [1:0]        status
);

    // configuration
    logic [15:0] addr_low_reg;
    logic [15:0] addr_high_reg;
    logic [7:0]  buf_size_reg;

    // request capture
    logic [2:0]  bytes_seen_reg;
    logic [15:0] start_addr_reg;
    logic [15:0] quantity_reg;
    logic [7:0]  fc_reg;
    logic        short_reg;
    logic [15:0] caddr_reg;
    logic        cval_reg;

    // coil store
    logic [7:0]  coil_mem [rcr_pkg::COIL_ROWS];
    logic [7:0]  rd_data_reg;
    logic [rcr_pkg::ROW_W-1:0] clr_row_reg;
    logic [rcr_pkg::ROW_W-1:0] rd_addr;
    logic        rd_en;
    logic [rcr_pkg::ROW_W-1:0] wr_addr;
    logic [7:0]  wr_data;
    logic        wr_en;

    // response packing
    logic [rcr_pkg::ROW_W-1:0] row_reg;
    logic        primed_reg;
    logic [15:0] win_reg;
    logic [15:0] win_next;
    logic [15:0] win_shifted;
    logic [7:0]  pack_byte;
    logic [63:0] word_reg;
    logic [3:0]  nbytes_reg;
    logic [7:0]  data_left_reg;

    // output register
    logic        out_valid_reg;
    logic [7:0]  out_fc_reg;
    logic [63:0] out_data_reg;
    logic [3:0]  out_nbytes_reg;
    logic        out_last_reg;
    logic [1:0]  out_status_reg;

    // request checks
    logic        qty_bad;
    logic [16:0] end_addr;
    logic        addr_bad;
    logic [10:0] qty_round;
    logic [7:0]  data_bytes;
    logic [8:0]  total_bytes;
    logic        buf_small;
    logic [7:0]  single_fc;
    logic [7:0]  single_data;
    logic [3:0]  single_nbytes;
    logic [1:0]  single_status;
    logic [7:0]  row_mod;

    always_comb
    begin
        qty_bad  = (quantity_reg == 16'd0) || (quantity_reg > rcr_pkg::MAX_QUANTITY);
        end_addr = {1'b0, start_addr_reg} + {1'b0, quantity_reg} - 17'd1;
        addr_bad = (start_addr_reg < addr_low_reg) || (start_addr_reg > addr_high_reg)
                || end_addr[16]
                || (end_addr[15:0] < addr_low_reg) || (end_addr[15:0] > addr_high_reg);
        qty_round   = quantity_reg[10:0] + 11'd7;
        data_bytes  = qty_round[10:3];
        total_bytes = {1'b0, data_bytes} + 9'd1;
        buf_small   = total_bytes > {1'b0, buf_size_reg};

        single_fc     = 8'h00;
        single_data   = 8'h00;
        single_nbytes = 4'd0;
        single_status = rcr_pkg::STS_OK;
        if (short_reg)
        begin
            single_status = rcr_pkg::STS_TRUNC;
        end
        else if (qty_bad || addr_bad)
        begin
            if (buf_size_reg == 8'd0)
            begin
                single_status = rcr_pkg::STS_BUF_SMALL;
            end
            else
            begin
                single_fc     = fc_reg + rcr_pkg::EXC_FLAG;
                single_data   = qty_bad ? rcr_pkg::EXC_ILLEGAL_VALUE
                                        : rcr_pkg::EXC_ILLEGAL_ADDR;
                single_nbytes = 4'd1;
            end
        end
        else
        begin
            single_status = rcr_pkg::STS_BUF_SMALL;
        end
    end

    // funnel the two buffered rows down to the coils of one response byte
    always_comb
    begin
        win_next    = {rd_data_reg, win_reg[15:8]};
        win_shifted = win_next >> start_addr_reg[2:0];
        pack_byte   = win_shifted[7:0];
        if (data_left_reg == 8'd1)
            pack_byte = pack_byte & rcr_pkg::tail_mask(quantity_reg[2:0]);
    end

    always_comb
    begin
        row_mod                 = rd_data_reg;
        row_mod[caddr_reg[2:0]] = cval_reg;

        rd_en   = cmd.coil_read || cmd.row_fetch;
        rd_addr = cmd.coil_read ? caddr_reg[15:3] : row_reg;
        wr_en   = cmd.clr_write || cmd.coil_write;
        wr_addr = cmd.clr_write ? clr_row_reg : caddr_reg[15:3];
        wr_data = cmd.clr_write ? 8'h00 : row_mod;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            coil_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= coil_mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_low_reg   <= 16'h0000;
            addr_high_reg  <= 16'hFFFF;
            buf_size_reg   <= 8'hFF;
            bytes_seen_reg <= 3'd0;
            start_addr_reg <= 16'h0000;
            quantity_reg   <= 16'h0000;
            short_reg      <= 1'b0;
            clr_row_reg    <= '0;
            primed_reg     <= 1'b0;
            nbytes_reg     <= 4'd0;
            data_left_reg  <= 8'd0;
            row_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rcr_pkg::CFG_ADDR_LOW:  addr_low_reg  <= cfg_data;
                    rcr_pkg::CFG_ADDR_HIGH: addr_high_reg <= cfg_data;
                    rcr_pkg::CFG_BUF_SIZE:  buf_size_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (cmd.take && (req_type == rcr_pkg::REQ_DATA))
            begin
                case (bytes_seen_reg)
                    3'd0: start_addr_reg[15:8] <= data_byte;
                    3'd1: start_addr_reg[7:0]  <= data_byte;
                    3'd2: quantity_reg[15:8]   <= data_byte;
                    3'd3: quantity_reg[7:0]    <= data_byte;
                    default: ;
                endcase
                if (last_byte)
                begin
                    bytes_seen_reg <= 3'd0;
                    short_reg      <= bytes_seen_reg < 3'd3;
                end
                else if (bytes_seen_reg < 3'd4)
                begin
                    bytes_seen_reg <= bytes_seen_reg + 3'd1;
                end
            end

            if (cmd.clr_write)
                clr_row_reg <= clr_row_reg + {{(rcr_pkg::ROW_W-1){1'b0}}, 1'b1};

            if (cmd.resp_start)
            begin
                row_reg       <= start_addr_reg[15:3];
                primed_reg    <= 1'b0;
                nbytes_reg    <= 4'd1;
                data_left_reg <= data_bytes;
            end

            if (cmd.row_fetch)
                row_reg <= row_reg + {{(rcr_pkg::ROW_W-1){1'b0}}, 1'b1};

            if (cmd.row_shift)
            begin
                primed_reg <= 1'b1;
                if (primed_reg)
                begin
                    nbytes_reg    <= nbytes_reg + 4'd1;
                    data_left_reg <= data_left_reg - 8'd1;
                end
            end

            if (cmd.word_push)
                nbytes_reg <= 4'd0;

            if (cmd.single_load || cmd.word_push)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.take && (req_type == rcr_pkg::REQ_DATA) && last_byte)
            fc_reg <= func_code;
        if (cmd.take && (req_type == rcr_pkg::REQ_COIL))
        begin
            caddr_reg <= coil_addr;
            cval_reg  <= coil_value;
        end
        if (cmd.resp_start)
            win_reg <= 16'h0000;
        if (cmd.row_shift)
            win_reg <= win_next;

        if (cmd.resp_start)
            word_reg <= {56'd0, data_bytes};
        else if (cmd.word_push)
            word_reg <= 64'd0;
        else if (cmd.row_shift && primed_reg)
            word_reg[{nbytes_reg[2:0], 3'b000} +: 8] <= pack_byte;

        if (cmd.single_load)
        begin
            out_fc_reg     <= single_fc;
            out_data_reg   <= {56'd0, single_data};
            out_nbytes_reg <= single_nbytes;
            out_last_reg   <= 1'b1;
            out_status_reg <= single_status;
        end
        else if (cmd.word_push)
        begin
            out_fc_reg     <= fc_reg;
            out_data_reg   <= word_reg;
            out_nbytes_reg <= nbytes_reg;
            out_last_reg   <= data_left_reg == 8'd0;
            out_status_reg <= rcr_pkg::STS_OK;
        end
    end

    always_comb
    begin
        sts.clr_done  = clr_row_reg == {rcr_pkg::ROW_W{1'b1}};
        sts.out_free  = !out_valid_reg || !out_stall;
        sts.single    = short_reg || qty_bad || addr_bad || buf_small;
        sts.primed    = primed_reg;
        sts.word_full = (nbytes_reg == 4'd7) || (data_left_reg == 8'd1);
        sts.last_word = data_left_reg == 8'd0;
    end

    assign out_valid      = out_valid_reg;
    assign resp_func_code = out_fc_reg;
    assign resp_data      = out_data_reg;
    assign resp_nbytes    = out_nbytes_reg;
    assign resp_last      = out_last_reg;
    assign status         = out_status_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.single_load || cmd.word_push) |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a word still waiting");

    a_nbytes_range: assert property (@(posedge clk) disable iff (!rst_n)
        nbytes_reg <= 4'd8)
        else $error("word byte count out of range");

    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.word_push |-> (nbytes_reg != 4'd0))
        else $error("empty word pushed");

endmodule

/* test/tb_read_coils_responder_core.sv */
// Testbench of the read-coils responder: directed and random requests checked against a coil mirror.
`timescale 1ns / 1ps

module tb_read_coils_responder_core;

    typedef struct packed {
        logic [7:0]  fc;
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
        logic [1:0]  st;
    } reply_word_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    localparam int IDLE_GAP   = 8;
    localparam int LONG_HOLD  = 600;
    localparam int ITEM_GOAL  = 410;
    localparam int TAIL_WAIT  = 20;
    localparam int REPORT_MAX = 10;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [1:0]  cfg_index   = rcr_pkg::CFG_ADDR_LOW;
    logic [15:0] cfg_data    = 16'h0000;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic        req_type    = rcr_pkg::REQ_DATA;
    logic [7:0]  func_code   = 8'h00;
    logic [7:0]  data_byte   = 8'h00;
    logic        last_byte   = 1'b0;
    logic [15:0] coil_addr   = 16'h0000;
    logic        coil_value  = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  resp_func_code;
    logic [63:0] resp_data;
    logic [3:0]  resp_nbytes;
    logic        resp_last;
    logic [1:0]  status;

    read_coils_responder_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .func_code      (func_code),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .coil_addr      (coil_addr),
        .coil_value     (coil_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .resp_func_code (resp_func_code),
        .resp_data      (resp_data),
        .resp_nbytes    (resp_nbytes),
        .resp_last      (resp_last),
        .status         (status)
    );

    always #10 clk = ~clk;

    // Mirror of the block: coil store, request collector and registers.
    bit          coil_img [0:65535];
    logic [2:0]  bytes_held = 3'd0;
    logic [15:0] start_acc  = 16'h0000;
    logic [15:0] qty_acc    = 16'h0000;
    logic [15:0] lo_addr    = 16'h0000;
    logic [15:0] hi_addr    = 16'hFFFF;
    logic [7:0]  buf_bytes  = 8'hFF;

    reply_word_t reply_words_due [$];

    int          err_count   = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    bit          gaps_on     = 1'b0;
    bit          mix_coils   = 1'b1;
    stall_mode_t stall_mode  = STALL_NONE;
    int          hold_ticket = 0;
    int          hold_served = 0;
    int          hold_cnt    = 0;
    int          stall_tick  = 0;
    logic [15:0] hot_base    = 16'h0000;

    function automatic reply_word_t single_word(input logic [7:0] fc, input logic [63:0] d,
                                                input logic [3:0] n, input logic [1:0] st);
        reply_word_t w;
        w.fc     = fc;
        w.data   = d;
        w.nbytes = n;
        w.last   = 1'b1;
        w.st     = st;
        return w;
    endfunction

    function automatic bit addr_in_range(input int a);
        return a >= int'(lo_addr) && a <= int'(hi_addr);
    endfunction

    // Fold one accepted beat into the mirror and queue the reply words it causes.
    task automatic coil_reply_for(input logic kind, input logic [7:0] fc, input logic [7:0] b,
                                  input logic lst, input logic [15:0] ca, input logic cv);
        int             held;
        int             s;
        int             q;
        int             last_addr;
        int             total;
        int             nwords;
        int             nb;
        logic [2047:0]  stream;
        reply_word_t    w;
        if (kind == rcr_pkg::REQ_COIL)
        begin
            coil_img[ca] = cv;
            return;
        end
        case (bytes_held)
            3'd0: start_acc[15:8] = b;
            3'd1: start_acc[7:0]  = b;
            3'd2: qty_acc[15:8]   = b;
            3'd3: qty_acc[7:0]    = b;
            default: ;
        endcase
        if (bytes_held < 3'd4)
            bytes_held = bytes_held + 3'd1;
        if (!lst)
            return;
        held = int'(bytes_held);
        bytes_held = 3'd0;
        if (held < 4)
        begin
            reply_words_due.push_back(single_word(8'h00, 64'd0, 4'd0, rcr_pkg::STS_TRUNC));
            return;
        end
        s = int'(start_acc);
        q = int'(qty_acc);
        if (q == 0 || q > int'(rcr_pkg::MAX_QUANTITY))
        begin
            if (buf_bytes == 8'd0)
                reply_words_due.push_back(single_word(8'h00, 64'd0, 4'd0,
                                                      rcr_pkg::STS_BUF_SMALL));
            else
                reply_words_due.push_back(single_word(fc + rcr_pkg::EXC_FLAG,
                                                      64'(rcr_pkg::EXC_ILLEGAL_VALUE),
                                                      4'd1, rcr_pkg::STS_OK));
            return;
        end
        last_addr = s + q - 1;
        if (!addr_in_range(s) || last_addr > 65535 || !addr_in_range(last_addr))
        begin
            if (buf_bytes == 8'd0)
                reply_words_due.push_back(single_word(8'h00, 64'd0, 4'd0,
                                                      rcr_pkg::STS_BUF_SMALL));
            else
                reply_words_due.push_back(single_word(fc + rcr_pkg::EXC_FLAG,
                                                      64'(rcr_pkg::EXC_ILLEGAL_ADDR),
                                                      4'd1, rcr_pkg::STS_OK));
            return;
        end
        total = 1 + (q + 7) / 8;
        if (total > int'(buf_bytes))
        begin
            reply_words_due.push_back(single_word(8'h00, 64'd0, 4'd0,
                                                  rcr_pkg::STS_BUF_SMALL));
            return;
        end
        stream = '0;
        stream[7:0] = 8'((q + 7) / 8);
        for (int i = 0; i < q; i++)
            stream[8 + i] = coil_img[s + i];
        nwords = (total + 7) / 8;
        for (int k = 0; k < nwords; k++)
        begin
            nb = total - 8 * k;
            if (nb > 8)
                nb = 8;
            w.fc     = fc;
            w.data   = stream[64 * k +: 64];
            w.nbytes = 4'(nb);
            w.last   = (k == nwords - 1);
            w.st     = rcr_pkg::STS_OK;
            reply_words_due.push_back(w);
        end
    endtask

    task automatic note_failure(input string msg);
        err_count++;
        if (err_count <= REPORT_MAX)
            $display("%s", msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
            note_failure($sformatf("%0t %s: expected %h, got %h", $time, name, want, got));
    endtask

    // Compare every accepted reply word with the oldest one due.
    always @(posedge clk)
    begin : word_check
        reply_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (reply_words_due.size() == 0)
                note_failure($sformatf("%0t unexpected word: fc %h data %h n %0d last %b st %0d",
                                       $time, resp_func_code, resp_data, resp_nbytes,
                                       resp_last, status));
            else
            begin
                exp_w = reply_words_due.pop_front();
                check_field("resp_func_code", 64'(exp_w.fc), 64'(resp_func_code));
                check_field("resp_data", exp_w.data, resp_data);
                check_field("resp_nbytes", 64'(exp_w.nbytes), 64'(resp_nbytes));
                check_field("resp_last", 64'(exp_w.last), 64'(resp_last));
                check_field("status", 64'(exp_w.st), 64'(status));
            end
        end
    end

    // Receiver: a long hold when asked, otherwise the current stall pattern.
    always @(posedge clk)
    begin
        stall_tick++;
        if (hold_ticket != hold_served)
        begin
            hold_served = hold_ticket;
            hold_cnt = LONG_HOLD;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: out_stall <= ((stall_tick % 11) < 4);
                default:        out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // Offer one beat and hold it until in_stall reads low after an edge, then return.
    task automatic send_item(input logic kind, input logic [7:0] fc, input logic [7:0] b,
                             input logic lst, input logic [15:0] ca, input logic cv);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid   <= 1'b1;
        req_type   <= kind;
        func_code  <= fc;
        data_byte  <= b;
        last_byte  <= lst;
        coil_addr  <= ca;
        coil_value <= cv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        coil_reply_for(kind, fc, b, lst, ca, cv);
        items_sent++;
    endtask

    // Drop valid and wait until every reply word has come, then let the block settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (reply_words_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            rcr_pkg::CFG_ADDR_LOW:  lo_addr = val;
            rcr_pkg::CFG_ADDR_HIGH: hi_addr = val;
            rcr_pkg::CFG_BUF_SIZE:  buf_bytes = val[7:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] rand_fc();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(0, 1) == 1)
            v = 8'h01;
        return v;
    endfunction

    function automatic logic [15:0] rand_coil_addr();
        logic [15:0] a;
        a = 16'($urandom);
        if ($urandom_range(0, 99) < 85)
            a = hot_base + 16'($urandom_range(0, 511));
        return a;
    endfunction

    function automatic logic [15:0] rand_qty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 16'($urandom_range(1, 40));
        else if (r < 90)
            return 16'($urandom_range(41, 300));
        else if (r < 97)
            return 16'($urandom_range(301, 1999));
        return rcr_pkg::MAX_QUANTITY;
    endfunction

    task automatic send_coil(input logic [15:0] a, input logic v);
        logic [7:0] junk_fc;
        logic [7:0] junk_b;
        junk_fc = 8'($urandom);
        junk_b  = 8'($urandom);
        send_item(rcr_pkg::REQ_COIL, junk_fc, junk_b, 1'($urandom_range(0, 1)), a, v);
    endtask

    // Start and quantity big-endian, then extra bytes; fc counts only on the last beat.
    task automatic send_request(input logic [15:0] st, input logic [15:0] q,
                                input logic [7:0] fc, input int extra);
        logic [7:0]  b;
        logic [7:0]  beat_fc;
        logic [15:0] junk_addr;
        int          n;
        n = 4 + extra;
        for (int k = 0; k < n; k++)
        begin
            if (mix_coils && $urandom_range(0, 9) == 0)
                send_coil(rand_coil_addr(), 1'($urandom_range(0, 1)));
            case (k)
                0: b = st[15:8];
                1: b = st[7:0];
                2: b = q[15:8];
                3: b = q[7:0];
                default: b = 8'($urandom);
            endcase
            beat_fc   = (k == n - 1) ? fc : rand_fc();
            junk_addr = 16'($urandom);
            send_item(rcr_pkg::REQ_DATA, beat_fc, b, k == n - 1, junk_addr,
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_short(input int n);
        logic [7:0]  b;
        logic [15:0] junk_addr;
        for (int k = 0; k < n; k++)
        begin
            b = 8'($urandom);
            junk_addr = 16'($urandom);
            send_item(rcr_pkg::REQ_DATA, rand_fc(), b, k == n - 1, junk_addr,
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic pick_modes();
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        gaps_on = $urandom_range(0, 2) != 0;
    endtask

    // Mostly well-formed requests over the hot window, with coil writes and broken requests.
    task automatic random_traffic(input int n);
        int          target;
        int          r;
        int          extra;
        logic [15:0] st;
        logic [15:0] q;
        target = items_sent + n;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 99);
            extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
            if (r < 35)
                send_coil(rand_coil_addr(), 1'($urandom_range(0, 1)));
            else if (r < 80)
            begin
                st = hot_base + 16'($urandom_range(0, 400));
                send_request(st, rand_qty(), rand_fc(), extra);
            end
            else if (r < 88)
            begin
                st = 16'($urandom);
                q = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(2001, 65535));
                send_request(st, q, rand_fc(), extra);
            end
            else if (r < 94)
            begin
                st = 16'hFFFF - 16'($urandom_range(0, 40));
                send_request(st, 16'($urandom_range(1, 80)), rand_fc(), extra);
            end
            else
                send_short($urandom_range(1, 3));
            if ($urandom_range(0, 99) < 3)
                wait_idle();
        end
    endtask

    task automatic test_directed();
        mix_coils = 1'b0;
        stall_mode = STALL_LIGHT;
        gaps_on = 1'b0;
        send_coil(16'h0000, 1'b1);
        send_coil(16'hFFFF, 1'b1);
        send_request(16'h0000, rcr_pkg::MAX_QUANTITY, 8'h01, 1);
        send_request(16'hFFFF, 16'd1, 8'h01, 0);
        send_request(16'h5A5A, 16'd0, 8'hFF, 0);
        send_request(16'h0000, 16'd2001, 8'h80, 0);
        send_request(16'hFFFF, 16'd2, 8'h01, 0);
        send_short(2);
        wait_idle();
        mix_coils = 1'b1;
    endtask

    task automatic test_clean_stream();
        hot_base = 16'($urandom);
        stall_mode = STALL_NONE;
        gaps_on = 1'b0;
        random_traffic(60);
        pick_modes();
        random_traffic(40);
        wait_idle();
    endtask

    task automatic test_address_window();
        logic [15:0] only;
        pick_modes();
        set_reg(rcr_pkg::CFG_ADDR_LOW, hot_base + 16'd100);
        set_reg(rcr_pkg::CFG_ADDR_HIGH, hot_base + 16'd350);
        random_traffic(40);
        wait_idle();
        only = hot_base + 16'd120;
        set_reg(rcr_pkg::CFG_ADDR_LOW, only);
        set_reg(rcr_pkg::CFG_ADDR_HIGH, only);
        send_request(only, 16'd1, rand_fc(), 0);
        send_request(only, 16'd2, rand_fc(), 0);
        random_traffic(15);
        wait_idle();
        // low above high: nothing is valid
        set_reg(rcr_pkg::CFG_ADDR_LOW, 16'hFFFF);
        set_reg(rcr_pkg::CFG_ADDR_HIGH, 16'h0000);
        random_traffic(20);
        wait_idle();
        set_reg(rcr_pkg::CFG_ADDR_HIGH, 16'hFFFF);
        send_coil(16'hFFFF, 1'b0);
        send_request(16'hFFFF, 16'd1, 8'h01, 0);
        send_request(16'hFFFE, 16'd2, 8'h01, 0);
        wait_idle();
        set_reg(rcr_pkg::CFG_ADDR_LOW, 16'h0000);
    endtask

    task automatic test_buffer_size();
        int sizes [5];
        sizes = '{0, 1, 2, $urandom_range(3, 12), 255};
        foreach (sizes[i])
        begin
            pick_modes();
            set_reg(rcr_pkg::CFG_BUF_SIZE, 16'(sizes[i]));
            random_traffic(18);
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        logic [15:0] st;
        stall_mode = STALL_NONE;
        gaps_on = 1'b0;
        hot_base = 16'($urandom);
        hold_ticket++;
        // keep offering while the receiver holds off, so the input backs up
        for (int k = 0; k < 12; k++)
        begin
            st = hot_base + 16'($urandom_range(0, 400));
            send_request(st, 16'($urandom_range(100, 400)), rand_fc(), 0);
        end
        wait_idle();
    endtask

    task automatic test_random_mix();
        while (items_sent < ITEM_GOAL)
        begin
            if ($urandom_range(0, 1) == 0)
                hot_base = 16'($urandom);
            pick_modes();
            random_traffic(30);
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_clean_stream();
        test_address_window();
        test_buffer_size();
        test_backpressure();
        test_random_mix();
        repeat (TAIL_WAIT) @(posedge clk);
        if (err_count == 0)
            $display("** read_coils_responder_core: PASSED **");
        else
            $display("** read_coils_responder_core: FAILED **");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("** read_coils_responder_core: FAILED **");
        $finish;
    end

endmodule
